// ----- hdl/cst_pkg.sv -----
// package for the child slot table: command codes, status codes and the
// control struct that travels along the row of slot cells
// no dependencies

package cst_pkg;

   // command codes of a request
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // status codes of a result
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DROPPED   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam int FLAG_W  = 8;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;
   localparam int COUNT_MAX = 31;

   // control part of the token handed from cell to cell
   typedef struct packed {
      logic    valid;   // a request is in this stage
      cmd_type cmd;     // its command
      logic    hit;     // some earlier cell has claimed the request
      logic    rvalid;  // valid bit of the claimed slot after the step
      logic    c0_fg;   // foreground contribution of slot 0
   } token_ctl_type;

endpackage

// ----- hdl/child_slot_table.sv -----
// child slot table: a request walks a row of TABLE_DEPTH slot cells, one per cycle.
// the token is registered in each cell, and the result again at the end of the row.
// busy holds off start until the request reaches the end of the row.
// the receiver cannot stall; each result is shown for exactly one cycle.
// reset empties every slot and sets the foreground mask to 1; no clearing pass.
// depends on cst_pkg and cst_cell

module child_slot_table
   import cst_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WIDTH   = 22
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_command,
   input  logic [KEY_WIDTH-1:0] req_key,
   input  logic [FLAG_W-1:0]    req_entry_flags,
   input  logic [INDEX_W-1:0]   req_slot_index,
   // result channel
   output logic                 rsp_valid,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [INDEX_W-1:0]   rsp_slot,
   output logic [KEY_WIDTH-1:0] rsp_found_key,
   output logic [FLAG_W-1:0]    rsp_found_flags,
   output logic                 rsp_found_valid,
   output logic [COUNT_W-1:0]   rsp_foreground_count,
   // configuration port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // token wires between cells
   token_ctl_type        tok_ctl    [TABLE_DEPTH+1];
   logic [KEY_WIDTH-1:0] tok_key    [TABLE_DEPTH+1];
   logic [FLAG_W-1:0]    tok_flags  [TABLE_DEPTH+1];
   logic [INDEX_W-1:0]   tok_idx    [TABLE_DEPTH+1];
   logic [SLOT_W-1:0]    tok_rslot  [TABLE_DEPTH+1];
   logic [KEY_WIDTH-1:0] tok_rkey   [TABLE_DEPTH+1];
   logic [FLAG_W-1:0]    tok_rflags [TABLE_DEPTH+1];
   logic [CNT_W-1:0]     tok_count  [TABLE_DEPTH+1];

   logic [FLAG_W-1:0]    mask_ff, mask_in;
   logic                 busy_ff, busy_in;
   logic                 accept, fix_wr;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic [INDEX_W-1:0]   slot_ff, slot_in;
   logic [KEY_WIDTH-1:0] fkey_ff, fkey_in;
   logic [FLAG_W-1:0]    fflags_ff, fflags_in;
   logic                 fvalid_ff, fvalid_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [SLOT_W+INDEX_W-1:0] slot_ext;
   logic [31:0]               cnt_wide;
   logic                      new_fg;
   token_ctl_type             last;

   assign accept = start && !busy_ff;
   assign last   = tok_ctl[TABLE_DEPTH];

   // request injection into the first cell
   always_comb begin
      tok_ctl[0].valid  = accept;
      tok_ctl[0].cmd    = cmd_type'(req_command);
      tok_ctl[0].hit    = 1'b0;
      tok_ctl[0].rvalid = 1'b0;
      tok_ctl[0].c0_fg  = 1'b0;
      tok_key[0]        = req_key;
      tok_flags[0]      = req_entry_flags;
      tok_idx[0]        = req_slot_index;
      tok_rslot[0]      = '0;
      tok_rkey[0]       = '0;
      tok_rflags[0]     = '0;
      tok_count[0]      = '0;
   end

   // full-table add: nobody claimed it, so slot 0 is replaced
   assign fix_wr = last.valid && (last.cmd == CMD_ADD) && !last.hit;

   // row of slot cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cst_cell #(
         .CELL_IDX  (i),
         .KEY_WIDTH (KEY_WIDTH),
         .SLOT_W    (SLOT_W),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .fg_mask    (mask_ff),
         .fix_wr     ((i == 0) && fix_wr),
         .fix_key    (tok_key[TABLE_DEPTH]),
         .fix_flags  (tok_flags[TABLE_DEPTH]),
         .in_ctl     (tok_ctl[i]),
         .in_key     (tok_key[i]),
         .in_flags   (tok_flags[i]),
         .in_idx     (tok_idx[i]),
         .in_rslot   (tok_rslot[i]),
         .in_rkey    (tok_rkey[i]),
         .in_rflags  (tok_rflags[i]),
         .in_count   (tok_count[i]),
         .out_ctl    (tok_ctl[i+1]),
         .out_key    (tok_key[i+1]),
         .out_flags  (tok_flags[i+1]),
         .out_idx    (tok_idx[i+1]),
         .out_rslot  (tok_rslot[i+1]),
         .out_rkey   (tok_rkey[i+1]),
         .out_rflags (tok_rflags[i+1]),
         .out_count  (tok_count[i+1])
      );
   end

   // busy from accept until the result is issued
   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (last.valid) busy_in = 1'b0;
   end

   // configuration write
   always_comb begin
      mask_in = mask_ff;
      if (psel && penable && pwrite && !paddr[2]) mask_in = pwdata[FLAG_W-1:0];
   end

   // result formation at the end of the row
   always_comb begin
      slot_ext     = {{INDEX_W{1'b0}}, tok_rslot[TABLE_DEPTH]};
      new_fg       = (tok_flags[TABLE_DEPTH] & mask_ff) != '0;
      cnt_wide     = 32'(tok_count[TABLE_DEPTH]);
      rsp_valid_in = last.valid;
      status_in    = ST_OK;
      slot_in      = slot_ext[INDEX_W-1:0];
      fkey_in      = tok_rkey[TABLE_DEPTH];
      fflags_in    = tok_rflags[TABLE_DEPTH];
      fvalid_in    = last.rvalid;

      case (last.cmd)
         CMD_ADD: begin
            if (!last.hit) begin
               status_in = ST_DROPPED;
               slot_in   = '0;
               fkey_in   = tok_key[TABLE_DEPTH];
               fflags_in = tok_flags[TABLE_DEPTH];
               fvalid_in = 1'b1;
               cnt_wide  = cnt_wide - 32'(last.c0_fg) + 32'(new_fg);
            end
         end
         CMD_READ: begin
            if (!last.hit) begin
               status_in = ST_NOT_FOUND;
               slot_in   = tok_idx[TABLE_DEPTH];
               fkey_in   = '0;
               fflags_in = '0;
               fvalid_in = 1'b0;
            end
         end
         default: begin
            if (!last.hit) begin
               status_in = ST_NOT_FOUND;
               slot_in   = '0;
               fkey_in   = '0;
               fflags_in = '0;
               fvalid_in = 1'b0;
            end
         end
      endcase

      // saturating count
      if (cnt_wide > 32'(COUNT_MAX)) cnt_wide = 32'(COUNT_MAX);
      count_in = cnt_wide[COUNT_W-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= FLAG_W'(1);
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      if (last.valid) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         fkey_ff   <= fkey_in;
         fflags_ff <= fflags_in;
         fvalid_ff <= fvalid_in;
         count_ff  <= count_in;
      end
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_slot             = slot_ff;
   assign rsp_found_key        = fkey_ff;
   assign rsp_found_flags      = fflags_ff;
   assign rsp_found_valid      = fvalid_ff;
   assign rsp_foreground_count = count_ff;

   // register read
   assign prdata = paddr[2] ? 32'd0 : {{(32-FLAG_W){1'b0}}, mask_ff};
   assign pready = 1'b1;

endmodule

// ----- hdl/cst_cell.sv -----
// one slot cell of the child slot table: holds valid, key and flags of one
// slot and passes the request token to its neighbor each cycle
// depends on cst_pkg

module cst_cell
   import cst_pkg::*;
#(
   parameter int CELL_IDX  = 0,
   parameter int KEY_WIDTH = 22,
   parameter int SLOT_W    = 4,
   parameter int CNT_W     = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [FLAG_W-1:0]    fg_mask,
   // direct write used to replace slot 0 when an add finds the table full
   input  logic                 fix_wr,
   input  logic [KEY_WIDTH-1:0] fix_key,
   input  logic [FLAG_W-1:0]    fix_flags,
   // token from the previous cell
   input  token_ctl_type        in_ctl,
   input  logic [KEY_WIDTH-1:0] in_key,
   input  logic [FLAG_W-1:0]    in_flags,
   input  logic [INDEX_W-1:0]   in_idx,
   input  logic [SLOT_W-1:0]    in_rslot,
   input  logic [KEY_WIDTH-1:0] in_rkey,
   input  logic [FLAG_W-1:0]    in_rflags,
   input  logic [CNT_W-1:0]     in_count,
   // token to the next cell
   output token_ctl_type        out_ctl,
   output logic [KEY_WIDTH-1:0] out_key,
   output logic [FLAG_W-1:0]    out_flags,
   output logic [INDEX_W-1:0]   out_idx,
   output logic [SLOT_W-1:0]    out_rslot,
   output logic [KEY_WIDTH-1:0] out_rkey,
   output logic [FLAG_W-1:0]    out_rflags,
   output logic [CNT_W-1:0]     out_count
);

   // slot storage
   logic                 valid_ff, valid_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [FLAG_W-1:0]    flags_ff, flags_in;

   // token stage
   token_ctl_type        ctl_ff, ctl_in;
   logic [KEY_WIDTH-1:0] tkey_ff, rkey_ff, rkey_in;
   logic [FLAG_W-1:0]    tflags_ff, rflags_ff, rflags_in;
   logic [INDEX_W-1:0]   idx_ff;
   logic [SLOT_W-1:0]    rslot_ff, rslot_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic take, wr, is_me, matched, contrib;

   // slot update and token processing
   always_comb begin
      ctl_in    = in_ctl;
      rslot_in  = in_rslot;
      rkey_in   = in_rkey;
      rflags_in = in_rflags;
      count_in  = in_count;
      valid_in  = valid_ff;
      key_in    = key_ff;
      flags_in  = flags_ff;
      take      = 1'b0;
      wr        = 1'b0;
      contrib   = 1'b0;
      is_me     = (32'(in_idx) == 32'(CELL_IDX));
      matched   = valid_ff && (key_ff == in_key);

      if (in_ctl.valid) begin
         case (in_ctl.cmd)
            CMD_ADD: begin
               if (!in_ctl.hit && !valid_ff) begin
                  take     = 1'b1;
                  wr       = 1'b1;
                  valid_in = 1'b1;
               end
            end
            CMD_FIND: begin
               if (!in_ctl.hit && matched) take = 1'b1;
            end
            CMD_REMOVE: begin
               if (!in_ctl.hit && matched) begin
                  take     = 1'b1;
                  valid_in = 1'b0;
               end
            end
            default: begin
               if (is_me) take = 1'b1;
            end
         endcase

         if (wr) begin
            key_in   = in_key;
            flags_in = in_flags;
         end

         if (take) begin
            ctl_in.hit    = 1'b1;
            ctl_in.rvalid = valid_in;
            rslot_in      = SLOT_W'(CELL_IDX);
            rkey_in       = key_in;
            rflags_in     = flags_in;
         end

         // count uses the slot as it stands after the step
         contrib  = valid_in && ((flags_in & fg_mask) != '0);
         count_in = in_count + CNT_W'(contrib);
         if (CELL_IDX == 0) ctl_in.c0_fg = contrib;
      end

      // slot 0 replacement on a full-table add
      if (fix_wr) begin
         valid_in = 1'b1;
         key_in   = fix_key;
         flags_in = fix_flags;
      end
   end

   // slot and token registers; only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ctl_ff.valid <= ctl_in.valid;
      end
      key_ff        <= key_in;
      flags_ff      <= flags_in;
      ctl_ff.cmd    <= ctl_in.cmd;
      ctl_ff.hit    <= ctl_in.hit;
      ctl_ff.rvalid <= ctl_in.rvalid;
      ctl_ff.c0_fg  <= ctl_in.c0_fg;
      tkey_ff       <= in_key;
      tflags_ff     <= in_flags;
      idx_ff        <= in_idx;
      rslot_ff      <= rslot_in;
      rkey_ff       <= rkey_in;
      rflags_ff     <= rflags_in;
      count_ff      <= count_in;
   end

   assign out_ctl    = ctl_ff;
   assign out_key    = tkey_ff;
   assign out_flags  = tflags_ff;
   assign out_idx    = idx_ff;
   assign out_rslot  = rslot_ff;
   assign out_rkey   = rkey_ff;
   assign out_rflags = rflags_ff;
   assign out_count  = count_ff;

endmodule
